// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tcs_pkg.sv =====
package tcs_pkg;

  localparam int unsigned SIDE_MAX   = 64;
  localparam int unsigned COUNT_MAX  = 8;
  localparam int unsigned COLUMN_MAX = 1024;

  localparam int unsigned SIDE_W   = 7;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned TEX_W    = 3;
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned SROW_W   = 10;
  localparam int unsigned HEIGHT_W = 11;
  localparam int unsigned TEXEL_W  = 32;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned PADDR_W  = 3;

  localparam int unsigned DEPTH   = SIDE_MAX * COUNT_MAX * SIDE_MAX;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned QUOT_W  = $clog2(SIDE_MAX);
  localparam int unsigned PITCH_W = $clog2(SIDE_MAX * COUNT_MAX + 1);
  localparam int unsigned NUM_W   = SROW_W + SIDE_W;
  localparam int unsigned REM_W   = NUM_W + 1;

  localparam int unsigned RESET_SIDE  = 64;
  localparam int unsigned RESET_COUNT = 1;

  localparam logic REG_SIDE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct packed {
    logic [SIDE_W-1:0]  side;
    logic [COUNT_W-1:0] count;
    logic [PITCH_W-1:0] pitch;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic               bad;
    logic [QUOT_W-1:0]  trow;
    logic [ADDR_W-1:0]  colbase;
    logic [TEXEL_W-1:0] value;
  } item_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(SIDE_MAX)) r = SIDE_W'(SIDE_MAX);
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = v;
    if (v == '0) r = COUNT_W'(1);
    else if (v > COUNT_W'(COUNT_MAX)) r = COUNT_W'(COUNT_MAX);
    return r;
  endfunction

endpackage

// ===== hdl/tcs_ram.sv =====
module tcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tcs_cfg.sv =====
module tcs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [tcs_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [tcs_pkg::PDATA_W-1:0]   pwdata_i,
  output logic [tcs_pkg::PDATA_W-1:0]   prdata_o,
  output tcs_pkg::cfg_t                 cfg_o
);

  localparam int unsigned PROD_W = tcs_pkg::SIDE_W + tcs_pkg::COUNT_W;

  logic [tcs_pkg::SIDE_W-1:0]  side_q, side_d;
  logic [tcs_pkg::COUNT_W-1:0] count_q, count_d;
  tcs_pkg::cfg_t               eff_q, eff_d;
  logic [tcs_pkg::SIDE_W-1:0]  side_new;
  logic [tcs_pkg::COUNT_W-1:0] count_new;
  logic [PROD_W-1:0]           pitch_side, pitch_count;
  logic                        wr;

  assign wr = psel_i && penable_i && pwrite_i;

  always_comb begin
    side_new    = tcs_pkg::clamp_side(pwdata_i[tcs_pkg::SIDE_W-1:0]);
    count_new   = tcs_pkg::clamp_count(pwdata_i[tcs_pkg::COUNT_W-1:0]);
    pitch_side  = PROD_W'(side_new) * PROD_W'(eff_q.count);
    pitch_count = PROD_W'(eff_q.side) * PROD_W'(count_new);
    side_d      = side_q;
    count_d     = count_q;
    eff_d       = eff_q;
    if (wr) begin
      unique case (paddr_i[2])
        tcs_pkg::REG_SIDE: begin
          side_d     = pwdata_i[tcs_pkg::SIDE_W-1:0];
          eff_d.side  = side_new;
          eff_d.pitch = pitch_side[tcs_pkg::PITCH_W-1:0];
        end
        tcs_pkg::REG_COUNT: begin
          count_d     = pwdata_i[tcs_pkg::COUNT_W-1:0];
          eff_d.count = count_new;
          eff_d.pitch = pitch_count[tcs_pkg::PITCH_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= tcs_pkg::SIDE_W'(tcs_pkg::RESET_SIDE);
      count_q     <= tcs_pkg::COUNT_W'(tcs_pkg::RESET_COUNT);
      eff_q.side  <= tcs_pkg::SIDE_W'(tcs_pkg::RESET_SIDE);
      eff_q.count <= tcs_pkg::COUNT_W'(tcs_pkg::RESET_COUNT);
      eff_q.pitch <= tcs_pkg::PITCH_W'(tcs_pkg::RESET_SIDE * tcs_pkg::RESET_COUNT);
    end else begin
      side_q  <= side_d;
      count_q <= count_d;
      eff_q   <= eff_d;
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      tcs_pkg::REG_SIDE:  prdata_o = tcs_pkg::PDATA_W'(side_q);
      tcs_pkg::REG_COUNT: prdata_o = tcs_pkg::PDATA_W'(count_q);
      default:            prdata_o = '0;
    endcase
  end

  assign cfg_o = eff_q;

endmodule

// ===== hdl/tcs_div.sv =====
module tcs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [tcs_pkg::NUM_W-1:0]     num_i,
  input  logic [tcs_pkg::HEIGHT_W-1:0]  den_i,
  input  tcs_pkg::item_t                item_i,
  output logic                          vld_o,
  output logic [tcs_pkg::QUOT_W-1:0]    quot_o,
  output tcs_pkg::item_t                item_o
);

  localparam int unsigned N = tcs_pkg::QUOT_W;

  // one quotient bit per stage, MSB first; quotient is known to fit in N bits
  logic                         vld_q  [N];
  logic [N-1:0]                 quot_q [N];
  tcs_pkg::item_t               item_q [N];
  logic [tcs_pkg::REM_W-1:0]    rem_q  [N-1];
  logic [tcs_pkg::HEIGHT_W-1:0] den_q  [N-1];

  logic [tcs_pkg::REM_W-1:0]    rem_in  [N];
  logic [tcs_pkg::HEIGHT_W-1:0] den_in  [N];
  logic [N-1:0]                 quot_in [N];
  logic                         vld_in  [N];
  tcs_pkg::item_t               item_in [N];
  logic [tcs_pkg::REM_W-1:0]    trial   [N];
  logic                         ge      [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s]  = tcs_pkg::REM_W'(num_i);
      assign den_in[s]  = den_i;
      assign quot_in[s] = '0;
      assign vld_in[s]  = vld_i;
      assign item_in[s] = item_i;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign den_in[s]  = den_q[s-1];
      assign quot_in[s] = quot_q[s-1];
      assign vld_in[s]  = vld_q[s-1];
      assign item_in[s] = item_q[s-1];
    end

    assign trial[s] = tcs_pkg::REM_W'(den_in[s]) << (N - 1 - s);
    assign ge[s]    = rem_in[s] >= trial[s];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      quot_q[s] <= {quot_in[s][N-2:0], ge[s]};
      item_q[s] <= item_in[s];
    end

    if (s < N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge[s] ? rem_in[s] - trial[s] : rem_in[s];
        den_q[s] <= den_in[s];
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign quot_o = quot_q[N-1];
  assign item_o = item_q[N-1];

endmodule

// ===== hdl/texture_column_scaler.sv =====
// Texture atlas with a nearest-neighbour column scaler.
// Items enter on start while busy is low; busy stays low, so one item is
// taken every clock. action selects a texel write or a scaled column read.
// A write stores texel_value_i at tex_coord_i + texture_id_i*side +
// texel_row_i*side*count; an out-of-range write is dropped with no result.
// A read gives one result: texel_o with range_error_o, marked by
// texel_valid_o for a single cycle, once through the stages below.
// Source row is (screen_row_i*side)/column_height_i, found by a six-stage
// restoring divider, one quotient bit per stage. Then one stage forms the
// row offset, one issues the atlas access, and the memory's registered read
// feeds the outputs. Writes and reads share this path, so each access meets
// the atlas in order and needs no forwarding. The receiver cannot stall:
// results must be taken in the cycle shown.
// The APB port holds texture_side at address 0 and texture_count at 4.
// Reset empties the pipeline and restores side 64 and count 1; the atlas
// keeps no reset value and must be written before it is read.
`include "assert_macros.svh"

module texture_column_scaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [tcs_pkg::TEX_W-1:0]     texture_id_i,
  input  logic [tcs_pkg::COORD_W-1:0]   tex_coord_i,
  input  logic [tcs_pkg::COORD_W-1:0]   texel_row_i,
  input  logic [tcs_pkg::TEXEL_W-1:0]   texel_value_i,
  input  logic [tcs_pkg::SROW_W-1:0]    screen_row_i,
  input  logic [tcs_pkg::HEIGHT_W-1:0]  column_height_i,
  output logic                          texel_valid_o,
  output logic [tcs_pkg::TEXEL_W-1:0]   texel_o,
  output logic                          range_error_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcs_pkg::PADDR_W-1:0]   paddr,
  input  logic [tcs_pkg::PDATA_W-1:0]   pwdata,
  output logic [tcs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned AW = tcs_pkg::ADDR_W;
  localparam int unsigned PW = tcs_pkg::SIDE_W + tcs_pkg::COUNT_W;

  tcs_pkg::cfg_t cfg;

  tcs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // front: range checks, dividend and column base
  logic                       accept;
  logic                       col_bad, tex_bad, row_bad, h_bad;
  tcs_pkg::item_t             item_d;
  logic [tcs_pkg::NUM_W-1:0]  num_d;

  assign accept = start && !busy;

  always_comb begin
    col_bad = tcs_pkg::SIDE_W'(tex_coord_i) >= cfg.side;
    tex_bad = tcs_pkg::COUNT_W'(texture_id_i) >= cfg.count;
    row_bad = tcs_pkg::SIDE_W'(texel_row_i) >= cfg.side;
    h_bad   = (column_height_i == '0)
           || (column_height_i > tcs_pkg::HEIGHT_W'(tcs_pkg::COLUMN_MAX))
           || (tcs_pkg::HEIGHT_W'(screen_row_i) >= column_height_i);
    item_d.action  = action_i;
    item_d.bad     = col_bad || tex_bad || ((action_i == tcs_pkg::ACT_READ) ? h_bad : row_bad);
    item_d.trow    = texel_row_i;
    item_d.colbase = AW'(tex_coord_i) + AW'(texture_id_i) * AW'(cfg.side);
    item_d.value   = texel_value_i;
    num_d          = tcs_pkg::NUM_W'(screen_row_i) * tcs_pkg::NUM_W'(cfg.side);
  end

  logic                          s1_vld_q;
  tcs_pkg::item_t                s1_item_q;
  logic [tcs_pkg::NUM_W-1:0]     s1_num_q;
  logic [tcs_pkg::HEIGHT_W-1:0]  s1_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= item_d;
    s1_num_q  <= num_d;
    s1_den_q  <= column_height_i;
  end

  logic                        dv_vld;
  logic [tcs_pkg::QUOT_W-1:0]  dv_quot;
  tcs_pkg::item_t              dv_item;

  tcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld_q),
    .num_i  (s1_num_q),
    .den_i  (s1_den_q),
    .item_i (s1_item_q),
    .vld_o  (dv_vld),
    .quot_o (dv_quot),
    .item_o (dv_item)
  );

  // row offset
  logic [tcs_pkg::QUOT_W-1:0] row;
  logic                       mul_vld_q;
  tcs_pkg::item_t             mul_item_q;
  logic [AW-1:0]              rowoff_q;

  assign row = (dv_item.action == tcs_pkg::ACT_READ) ? dv_quot : dv_item.trow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_item_q <= dv_item;
    rowoff_q   <= AW'(row) * AW'(cfg.pitch);
  end

  // atlas access
  logic [AW-1:0]               ram_addr;
  logic                        ram_we;
  logic [tcs_pkg::TEXEL_W-1:0] ram_rdata;

  assign ram_addr = rowoff_q + mul_item_q.colbase;
  assign ram_we   = mul_vld_q && (mul_item_q.action == tcs_pkg::ACT_WRITE) && !mul_item_q.bad;

  tcs_ram #(
    .WIDTH (tcs_pkg::TEXEL_W),
    .DEPTH (tcs_pkg::DEPTH)
  ) u_atlas (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (mul_item_q.value),
    .rdata_o (ram_rdata)
  );

  logic out_vld_q;
  logic out_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= mul_vld_q && (mul_item_q.action == tcs_pkg::ACT_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    out_bad_q <= mul_item_q.bad;
  end

  assign texel_valid_o = out_vld_q;
  assign range_error_o = out_bad_q;
  assign texel_o       = out_bad_q ? '0 : ram_rdata;

  `TCS_ASSERT_IMP(a_result_has_read, texel_valid_o, $past(start && !busy && action_i == tcs_pkg::ACT_READ, 9), "result without a read transaction 9 cycles earlier")
  `TCS_ASSERT_NXT(a_read_gives_result, mul_vld_q && mul_item_q.action == tcs_pkg::ACT_READ, texel_valid_o, "read issued to atlas but no result strobe")
  `TCS_ASSERT_IMP(a_error_zero, texel_valid_o && range_error_o, texel_o == '0, "errored result carries a non-zero texel")
  `TCS_ASSERT_IMP(a_pitch, 1'b1, PW'(cfg.side) * PW'(cfg.count) == PW'(cfg.pitch), "row pitch out of step with side and count")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tcs_pkg::*;

  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned TAIL_CYCLES   = 24;
  localparam int unsigned ITEM_TARGET   = 1650;
  localparam int unsigned PHASES        = 7;

  typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_HOLD} job_e;
  typedef enum logic [1:0] {DRV_RUN, DRV_DRAIN, DRV_SETUP, DRV_ACCESS} drv_e;

  typedef struct {
    job_e                kind;
    int unsigned         gap_pct;
    logic                act;
    logic [TEX_W-1:0]    tex;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  trow;
    logic [TEXEL_W-1:0]  value;
    logic [SROW_W-1:0]   srow;
    logic [HEIGHT_W-1:0] height;
    logic                reg_sel;
    logic [PDATA_W-1:0]  cfg_data;
  } stim_t;

  typedef struct {
    logic [TEXEL_W-1:0] texel;
    logic               range_error;
  } texel_exp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                action_i = ACT_WRITE;
  logic [TEX_W-1:0]    texture_id_i = '0;
  logic [COORD_W-1:0]  tex_coord_i = '0;
  logic [COORD_W-1:0]  texel_row_i = '0;
  logic [TEXEL_W-1:0]  texel_value_i = '0;
  logic [SROW_W-1:0]   screen_row_i = '0;
  logic [HEIGHT_W-1:0] column_height_i = '0;
  logic                texel_valid_o;
  logic [TEXEL_W-1:0]  texel_o;
  logic                range_error_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  texture_column_scaler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .texture_id_i    (texture_id_i),
    .tex_coord_i     (tex_coord_i),
    .texel_row_i     (texel_row_i),
    .texel_value_i   (texel_value_i),
    .screen_row_i    (screen_row_i),
    .column_height_i (column_height_i),
    .texel_valid_o   (texel_valid_o),
    .texel_o         (texel_o),
    .range_error_o   (range_error_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  stim_t              pending_q[$];
  texel_exp_t         texel_due_q[$];

  // mirror of the atlas and registers, updated on accepted transactions
  logic [TEXEL_W-1:0] atlas_mirror [DEPTH];
  logic [SIDE_W-1:0]  side_reg = SIDE_W'(RESET_SIDE);
  logic [COUNT_W-1:0] count_reg = COUNT_W'(RESET_COUNT);

  // stimulus-side view: shape in force and entries already written
  bit                 gen_written [DEPTH];
  int unsigned        gen_side = RESET_SIDE;
  int unsigned        gen_count = RESET_COUNT;
  int unsigned        gen_total = 0;

  int unsigned        n_sent = 0;
  int unsigned        n_taken = 0;
  int unsigned        stall_cycles = 0;
  int unsigned        settle = 0;
  drv_e               drv_state = DRV_RUN;
  bit                 fail_seen = 1'b0;

  function automatic int unsigned limit_dim(int unsigned raw, int unsigned top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  function automatic int unsigned atlas_index(int unsigned col, int unsigned tex,
                                              int unsigned row, int unsigned side,
                                              int unsigned count);
    return col + tex * side + row * side * count;
  endfunction

  task automatic scale_and_fetch();
    int unsigned side;
    int unsigned count;
    int unsigned src;
    bit          bad;
    texel_exp_t  r;
    side  = limit_dim(side_reg, SIDE_MAX);
    count = limit_dim(count_reg, COUNT_MAX);
    bad   = (tex_coord_i >= side) || (texture_id_i >= count);
    if (action_i == ACT_WRITE) begin
      if (!bad && texel_row_i < side)
        atlas_mirror[atlas_index(tex_coord_i, texture_id_i, texel_row_i, side, count)] =
          texel_value_i;
    end else begin
      if (column_height_i == 0 || column_height_i > COLUMN_MAX ||
          screen_row_i >= column_height_i)
        bad = 1'b1;
      r.texel       = '0;
      r.range_error = bad;
      if (!bad) begin
        src     = screen_row_i * side / column_height_i;
        r.texel = atlas_mirror[atlas_index(tex_coord_i, texture_id_i, src, side, count)];
      end
      texel_due_q.push_back(r);
    end
  endtask

  function automatic stim_t noise_item();
    stim_t s;
    s.kind     = JOB_ITEM;
    s.gap_pct  = 0;
    s.act      = $urandom;
    s.tex      = $urandom;
    s.col      = $urandom;
    s.trow     = $urandom;
    s.value    = $urandom;
    s.srow     = $urandom;
    s.height   = $urandom;
    s.reg_sel  = REG_SIDE;
    s.cfg_data = '0;
    return s;
  endfunction

  function automatic int unsigned pick_height();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return COLUMN_MAX;
    if (r < 70) return $urandom_range(64, 1);
    return $urandom_range(COLUMN_MAX, 65);
  endfunction

  task automatic push_item(stim_t s);
    if (gen_total < ITEM_TARGET / 3) s.gap_pct = 21;
    else if (gen_total < 2 * ITEM_TARGET / 3) s.gap_pct = 78;
    else s.gap_pct = 0;
    pending_q.push_back(s);
    gen_total++;
  endtask

  task automatic queue_write(stim_t s);
    s.act = ACT_WRITE;
    if (s.col < gen_side && s.tex < gen_count && s.trow < gen_side)
      gen_written[atlas_index(s.col, s.tex, s.trow, gen_side, gen_count)] = 1'b1;
    push_item(s);
  endtask

  // a valid read of a never-written entry gets that entry written first
  task automatic queue_read(stim_t s);
    int unsigned src;
    stim_t       w;
    s.act = ACT_READ;
    if (s.col < gen_side && s.tex < gen_count && s.height != 0 &&
        s.height <= COLUMN_MAX && s.srow < s.height) begin
      src = s.srow * gen_side / s.height;
      if (!gen_written[atlas_index(s.col, s.tex, src, gen_side, gen_count)]) begin
        w      = noise_item();
        w.tex  = s.tex;
        w.col  = s.col;
        w.trow = src;
        queue_write(w);
      end
    end
    push_item(s);
  endtask

  task automatic queue_cfg(logic sel, int unsigned raw);
    stim_t s;
    s         = noise_item();
    s.kind    = JOB_CFG;
    s.reg_sel = sel;
    if (sel == REG_SIDE) begin
      s.cfg_data = ($urandom << SIDE_W) | raw;
      gen_side   = limit_dim(raw, SIDE_MAX);
    end else begin
      s.cfg_data = ($urandom << COUNT_W) | raw;
      gen_count  = limit_dim(raw, COUNT_MAX);
    end
    pending_q.push_back(s);
  endtask

  task automatic queue_hold();
    stim_t s;
    s      = noise_item();
    s.kind = JOB_HOLD;
    pending_q.push_back(s);
  endtask

  task automatic random_traffic();
    stim_t       s;
    int unsigned pick;
    s    = noise_item();
    pick = $urandom_range(99);
    if (pick < 30) begin
      s.tex  = $urandom_range(gen_count - 1);
      s.col  = $urandom_range(gen_side - 1);
      s.trow = $urandom_range(gen_side - 1);
      queue_write(s);
    end else if (pick < 35) begin
      queue_write(s);
    end else if (pick < 85) begin
      s.tex    = $urandom_range(gen_count - 1);
      s.col    = $urandom_range(gen_side - 1);
      s.height = pick_height();
      s.srow   = $urandom_range(s.height - 1);
      queue_read(s);
    end else begin
      queue_read(s);
    end
  endtask

  // fill one texture column, then scan a run of screen rows through it
  task automatic column_sweep();
    stim_t       s;
    int unsigned tex;
    int unsigned col;
    int unsigned h;
    int unsigned first;
    int unsigned n;
    tex = $urandom_range(gen_count - 1);
    col = $urandom_range(gen_side - 1);
    for (int unsigned row = 0; row < gen_side; row++) begin
      s      = noise_item();
      s.tex  = tex;
      s.col  = col;
      s.trow = row;
      queue_write(s);
    end
    h     = pick_height();
    first = $urandom_range(h - 1);
    n     = $urandom_range(24, 4);
    for (int unsigned k = 0; k < n && first + k <= h && first + k < COLUMN_MAX; k++) begin
      s        = noise_item();
      s.tex    = tex;
      s.col    = col;
      s.srow   = first + k;
      s.height = h;
      queue_read(s);
    end
  endtask

  task automatic directed_read(int unsigned tex, int unsigned col, int unsigned srow,
                               int unsigned h);
    stim_t s;
    s        = noise_item();
    s.tex    = tex;
    s.col    = col;
    s.srow   = srow;
    s.height = h;
    queue_read(s);
  endtask

  task automatic directed_write(int unsigned tex, int unsigned col, int unsigned row,
                                logic [TEXEL_W-1:0] value);
    stim_t s;
    s       = noise_item();
    s.tex   = tex;
    s.col   = col;
    s.trow  = row;
    s.value = value;
    queue_write(s);
  endtask

  task automatic build_stimulus();
    int unsigned side_raw [PHASES];
    int unsigned count_raw [PHASES];
    int unsigned phase_end;
    int unsigned hold_at;
    bit          held;
    side_raw  = '{64, 1, 64, 0, 127, 37, 0};
    count_raw = '{1, 8, 8, 0, 15, 3, 0};
    side_raw[PHASES-1]  = $urandom_range(127);
    count_raw[PHASES-1] = $urandom_range(15);
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        queue_cfg(REG_SIDE, side_raw[p]);
        queue_cfg(REG_COUNT, count_raw[p]);
      end else begin
        directed_write(0, 0, 0, 32'h0000_0000);
        directed_write(0, 63, 63, 32'hFFFF_FFFF);
        directed_write(0, 0, 63, 32'h8000_0001);
        directed_write(1, 5, 5, 32'h1234_5678);
        directed_read(0, 0, 0, 1);
        directed_read(0, 63, 1023, 1024);
        directed_read(0, 0, 1023, 1024);
        directed_read(0, 63, 0, 1024);
        directed_read(1, 0, 0, 1);
        directed_read(7, 63, 0, 1);
        directed_read(0, 0, 0, 0);
        directed_read(0, 0, 0, 1025);
        directed_read(0, 0, 1023, 2047);
        directed_read(0, 0, 5, 5);
        directed_read(0, 0, 1023, 1023);
        directed_read(0, 31, 512, 1000);
      end
      phase_end = ITEM_TARGET * (p + 1) / PHASES;
      hold_at   = gen_total + (phase_end - gen_total) / 2;
      held      = 1'b0;
      while (gen_total < phase_end) begin
        if (!held && gen_total >= hold_at) begin
          queue_hold();
          held = 1'b1;
        end
        if ($urandom_range(99) < 4) column_sweep();
        else random_traffic();
      end
    end
  endtask

  task automatic present(stim_t s);
    start           <= 1'b1;
    action_i        <= s.act;
    texture_id_i    <= s.tex;
    tex_coord_i     <= s.col;
    texel_row_i     <= s.trow;
    texel_value_i   <= s.value;
    screen_row_i    <= s.srow;
    column_height_i <= s.height;
    n_sent++;
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      case (drv_state)
        DRV_RUN: begin
          if (!(start && n_taken != n_sent)) begin
            if (pending_q.size() == 0) begin
              start <= 1'b0;
            end else if (pending_q[0].kind != JOB_ITEM) begin
              start     <= 1'b0;
              settle    = 0;
              drv_state = DRV_DRAIN;
            end else if ($urandom_range(99) < pending_q[0].gap_pct) begin
              start <= 1'b0;
            end else begin
              present(pending_q.pop_front());
            end
          end
        end
        DRV_DRAIN: begin
          if (texel_due_q.size() == 0) begin
            if (pending_q[0].kind == JOB_HOLD) begin
              void'(pending_q.pop_front());
              drv_state = DRV_RUN;
            end else if (settle < SETTLE_CYCLES) begin
              settle++;
            end else begin
              psel      <= 1'b1;
              penable   <= 1'b0;
              pwrite    <= 1'b1;
              paddr     <= {pending_q[0].reg_sel, 2'b00};
              pwdata    <= pending_q[0].cfg_data;
              drv_state = DRV_SETUP;
            end
          end
        end
        DRV_SETUP: begin
          penable   <= 1'b1;
          drv_state = DRV_ACCESS;
        end
        default: begin
          psel      <= 1'b0;
          penable   <= 1'b0;
          pwrite    <= 1'b0;
          void'(pending_q.pop_front());
          drv_state = DRV_RUN;
        end
      endcase
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      bit         moved;
      texel_exp_t want;
      moved = 1'b0;
      if (texel_valid_o) begin
        moved = 1'b1;
        if (texel_due_q.size() == 0) begin
          $error("texel transaction with none outstanding: texel %h range_error %b",
                 texel_o, range_error_o);
          fail_seen = 1'b1;
        end else begin
          want = texel_due_q.pop_front();
          if (texel_o !== want.texel) begin
            $error("texel: expected %h, got %h", want.texel, texel_o);
            fail_seen = 1'b1;
          end
          if (range_error_o !== want.range_error) begin
            $error("range_error: expected %b, got %b", want.range_error, range_error_o);
            fail_seen = 1'b1;
          end
        end
      end
      if (start && !busy) begin
        scale_and_fetch();
        n_taken++;
        moved = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_SIDE) side_reg = pwdata[SIDE_W-1:0];
        else count_reg = pwdata[COUNT_W-1:0];
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (pending_q.size() != 0 || n_taken != n_sent || drv_state != DRV_RUN ||
           texel_due_q.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (!fail_seen && texel_due_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
